// ===== hw/rtl/wpd_pkg.sv =====
package wpd_pkg;

  localparam int NUM_TYPES_DEF  = 4;
  localparam int POOL_DEPTH_DEF = 64;

  localparam int OPC_W    = 2;
  localparam int TYPE_W   = 3;
  localparam int ID_W     = 16;
  localparam int RARITY_W = 2;
  localparam int WEIGHT_W = 16;
  localparam int ROLL_W   = 22;
  localparam int STATUS_W = 3;

  localparam logic [OPC_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OPC_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OPC_W-1:0] OP_COMMIT = 2'd2;
  localparam logic [OPC_W-1:0] OP_DRAW   = 2'd3;

  localparam logic [RARITY_W-1:0] RARITY_BAD = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_LOADED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_TYPE   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_ID     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_RARITY = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd6;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd7;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [RARITY_W-1:0] rarity;
    logic [WEIGHT_W-1:0] weight;
  } slot_t;

endpackage

// ===== hw/rtl/wpd_slot_mem.sv =====
module wpd_slot_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic           clk,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  wpd_pkg::slot_t wr_data,
  input  logic           rd_en,
  input  logic [AW-1:0]  rd_addr,
  output wpd_pkg::slot_t rd_data
);
  import wpd_pkg::*;

  slot_t mem [DEPTH];
  slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/wpd_cmp_unit.sv =====
module wpd_cmp_unit (
  input  logic                         draw_mode,
  input  logic [wpd_pkg::ROLL_W-1:0]   roll,
  input  logic [wpd_pkg::ID_W-1:0]     key_id,
  input  wpd_pkg::slot_t               entry,
  output logic                         hit,
  output logic [wpd_pkg::ROLL_W-1:0]   roll_rem
);
  import wpd_pkg::*;

  logic [ROLL_W-1:0] weight_ext;

  assign weight_ext = ROLL_W'(entry.weight);
  assign roll_rem   = roll - weight_ext;
  assign hit        = draw_mode ? (roll <= weight_ext) : (entry.id == key_id);

endmodule

// ===== hw/rtl/weighted_pool_draw.sv =====
// weighted candidate pools, one per draw type, with roulette-wheel draw
// input channel: in_valid/in_ready carry one item (opcode, type, entry, roll)
// output channel: out_valid/out_ready carry one result item per input item
// clear, commit and items rejected in S_CHECK skip the walk and go from S_CHECK to S_OUT
// insert: walks the pool for a duplicate id, then appends unless the weight is zero or the pool is full
// draw: walks the pool one entry per cycle through the slot memory read port
// one item is worked at a time; in_ready is high only while the sequencer idles
// the next item is taken only after the result is loaded and S_OUT returns to S_IDLE
// a finished result sits in the output register, so the next item is taken
//   while the receiver stalls; a second result waits until that one is taken
// reset clears pool counts, the loaded flag and both handshakes; slot contents
//   are not cleared and no clearing pass runs, the block is ready right away
module weighted_pool_draw #(
  parameter int NUM_TYPES  = wpd_pkg::NUM_TYPES_DEF,
  parameter int POOL_DEPTH = wpd_pkg::POOL_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [wpd_pkg::OPC_W-1:0]     in_opcode,
  input  logic [wpd_pkg::TYPE_W-1:0]    in_pool_type,
  input  logic [wpd_pkg::ID_W-1:0]      in_entry_id,
  input  logic [wpd_pkg::RARITY_W-1:0]  in_entry_rarity,
  input  logic [wpd_pkg::WEIGHT_W-1:0]  in_entry_weight,
  input  logic [wpd_pkg::ROLL_W-1:0]    in_roll,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [wpd_pkg::STATUS_W-1:0]  out_status,
  output logic [wpd_pkg::ID_W-1:0]      out_drawn_id,
  output logic [wpd_pkg::RARITY_W-1:0]  out_drawn_rarity,
  output logic                          out_table_loaded
);
  import wpd_pkg::*;

  localparam int TOTAL = NUM_TYPES * POOL_DEPTH;
  localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int IW    = $clog2(POOL_DEPTH + 1);
  localparam int TW    = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [OPC_W-1:0]    op_r;
  logic [TYPE_W-1:0]   type_r;
  logic [ID_W-1:0]     id_r;
  logic [RARITY_W-1:0] rar_r;
  logic [WEIGHT_W-1:0] wt_r;
  logic [ROLL_W-1:0]   roll_r, roll_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic                iss_r, iss_nxt;
  logic                loaded_r, loaded_nxt;
  logic [IW-1:0]       cnt_r [NUM_TYPES];

  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [ID_W-1:0]     res_id_r, res_id_nxt;
  logic [RARITY_W-1:0] res_rar_r, res_rar_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [ID_W-1:0]     out_id_r;
  logic [RARITY_W-1:0] out_rar_r;
  logic                out_loaded_r;

  logic                in_acc;
  logic                out_load;
  logic                type_ok;
  logic [TW-1:0]       pidx;
  logic [IW-1:0]       cur_cnt;
  logic                all_nz;
  logic                clr_tbl;
  logic                cnt_inc;
  logic                issue;
  logic                hit;

  logic                wr_en;
  logic                rd_en;
  logic [AW-1:0]       wr_addr;
  logic [AW-1:0]       rd_addr;
  slot_t               wr_data;
  slot_t               rd_data;
  logic                unit_hit;
  logic [ROLL_W-1:0]   unit_rem;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  assign type_ok = (type_r != '0) && (type_r <= TYPE_W'(NUM_TYPES));
  assign pidx    = TW'(type_r - TYPE_W'(1));
  assign cur_cnt = cnt_r[pidx];

  always_comb begin
    all_nz = 1'b1;
    for (int i = 0; i < NUM_TYPES; i++) begin
      all_nz = all_nz && (cnt_r[i] != '0);
    end
  end

  assign rd_addr = AW'(int'(pidx) * POOL_DEPTH + int'(idx_r));
  assign wr_addr = AW'(int'(pidx) * POOL_DEPTH + int'(cur_cnt));
  assign wr_data = '{id: id_r, rarity: rar_r, weight: wt_r};

  wpd_slot_mem #(
    .DEPTH (TOTAL),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  wpd_cmp_unit u_cmp (
    .draw_mode (op_r == OP_DRAW),
    .roll      (roll_r),
    .key_id    (id_r),
    .entry     (rd_data),
    .hit       (unit_hit),
    .roll_rem  (unit_rem)
  );

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    iss_nxt        = 1'b0;
    roll_nxt       = roll_r;
    loaded_nxt     = loaded_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_rar_nxt    = res_rar_r;
    clr_tbl        = 1'b0;
    cnt_inc        = 1'b0;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    issue          = 1'b0;
    hit            = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        res_status_nxt = ST_OK;
        res_id_nxt     = '0;
        res_rar_nxt    = '0;
        idx_nxt        = '0;
        state_nxt      = S_OUT;
        case (op_r)
          OP_CLEAR: begin
            clr_tbl = 1'b1;
          end
          OP_INSERT: begin
            loaded_nxt = 1'b0;
            if (!type_ok) begin
              res_status_nxt = ST_BAD_TYPE;
              clr_tbl        = 1'b1;
            end else if (rar_r == RARITY_BAD) begin
              res_status_nxt = ST_BAD_RARITY;
              clr_tbl        = 1'b1;
            end else if (id_r == '0) begin
              res_status_nxt = ST_BAD_ID;
              clr_tbl        = 1'b1;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          OP_COMMIT: begin
            if (all_nz) begin
              loaded_nxt = 1'b1;
            end else begin
              res_status_nxt = ST_EMPTY;
              clr_tbl        = 1'b1;
            end
          end
          OP_DRAW: begin
            if (!loaded_r) begin
              res_status_nxt = ST_NOT_LOADED;
            end else if (!type_ok) begin
              res_status_nxt = ST_BAD_TYPE;
            end else if (cur_cnt == '0) begin
              res_status_nxt = ST_EMPTY;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          default: begin
            state_nxt = S_OUT;
          end
        endcase
      end
      S_SCAN: begin
        hit     = iss_r && unit_hit;
        issue   = !hit && (idx_r < cur_cnt);
        rd_en   = issue;
        iss_nxt = issue;
        if (issue) begin
          idx_nxt = idx_r + IW'(1);
        end
        if (hit) begin
          state_nxt = S_OUT;
          if (op_r == OP_DRAW) begin
            res_id_nxt  = rd_data.id;
            res_rar_nxt = rd_data.rarity;
          end else begin
            res_status_nxt = ST_DUPLICATE;
            clr_tbl        = 1'b1;
          end
        end else begin
          if (iss_r) begin
            roll_nxt = unit_rem;
          end
          if (!iss_r && !issue) begin
            state_nxt = S_OUT;
            if (op_r == OP_DRAW) begin
              res_id_nxt  = rd_data.id;
              res_rar_nxt = rd_data.rarity;
            end else if (wt_r == '0) begin
              res_status_nxt = ST_OK;
            end else if (cur_cnt == IW'(POOL_DEPTH)) begin
              res_status_nxt = ST_FULL;
              clr_tbl        = 1'b1;
            end else begin
              wr_en   = 1'b1;
              cnt_inc = 1'b1;
            end
          end
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (clr_tbl) begin
      loaded_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iss_r       <= 1'b0;
      loaded_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_r       <= iss_nxt;
      loaded_r    <= loaded_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TYPES; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (clr_tbl) begin
      for (int i = 0; i < NUM_TYPES; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (cnt_inc) begin
      cnt_r[pidx] <= cur_cnt + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_opcode;
      type_r <= in_pool_type;
      id_r   <= in_entry_id;
      rar_r  <= in_entry_rarity;
      wt_r   <= in_entry_weight;
      roll_r <= in_roll;
    end else begin
      roll_r <= roll_nxt;
    end
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_rar_r    <= res_rar_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_id_r     <= res_id_r;
      out_rar_r    <= res_rar_r;
      out_loaded_r <= loaded_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_drawn_id     = out_id_r;
  assign out_drawn_rarity = out_rar_r;
  assign out_table_loaded = out_loaded_r;

endmodule

// ===== bench/weighted_pool_draw_tb.sv =====
`timescale 1ns / 100ps

module weighted_pool_draw_tb;
  import wpd_pkg::*;

  localparam int NT = NUM_TYPES_DEF;
  localparam int PD = POOL_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1200;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int N_DIRECTED = 25;

  typedef struct packed {
    logic [OPC_W-1:0]    op;
    logic [TYPE_W-1:0]   ptype;
    logic [ID_W-1:0]     id;
    logic [RARITY_W-1:0] rarity;
    logic [WEIGHT_W-1:0] weight;
    logic [ROLL_W-1:0]   roll;
  } pool_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id;
    logic [RARITY_W-1:0] rarity;
    logic                loaded;
  } draw_res_t;

  typedef struct packed {
    pool_req_t req;
    logic      typed;
    draw_res_t want;
  } dir_row_t;

  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{'{OP_DRAW,   3'd1, 16'd0,     2'd0, 16'd0,     22'd5},       1'b1,
      '{ST_NOT_LOADED, 16'd0, 2'd0, 1'b0}},
    '{'{OP_COMMIT, 3'd0, 16'd0,     2'd0, 16'd0,     22'd0},       1'b1,
      '{ST_EMPTY, 16'd0, 2'd0, 1'b0}},
    '{'{OP_INSERT, 3'd0, 16'd1,     2'd0, 16'd1,     22'd0},       1'b1,
      '{ST_BAD_TYPE, 16'd0, 2'd0, 1'b0}},
    '{'{OP_INSERT, 3'd7, 16'd1,     2'd0, 16'd1,     22'd0},       1'b1,
      '{ST_BAD_TYPE, 16'd0, 2'd0, 1'b0}},
    '{'{OP_INSERT, 3'd1, 16'd5,     2'd3, 16'd10,    22'd0},       1'b1,
      '{ST_BAD_RARITY, 16'd0, 2'd0, 1'b0}},
    '{'{OP_INSERT, 3'd1, 16'd0,     2'd0, 16'd10,    22'd0},       1'b1,
      '{ST_BAD_ID, 16'd0, 2'd0, 1'b0}},
    '{'{OP_INSERT, 3'd1, 16'hFFFF,  2'd2, 16'hFFFF,  22'd0},       1'b1,
      '{ST_OK, 16'd0, 2'd0, 1'b0}},
    '{'{OP_INSERT, 3'd1, 16'd1,     2'd0, 16'd1,     22'd0},       1'b1,
      '{ST_OK, 16'd0, 2'd0, 1'b0}},
    '{'{OP_INSERT, 3'd1, 16'd1,     2'd1, 16'd7,     22'd0},       1'b1,
      '{ST_DUPLICATE, 16'd0, 2'd0, 1'b0}},
    '{'{OP_INSERT, 3'd1, 16'hFFFF,  2'd2, 16'hFFFF,  22'd0},       1'b0, '0},
    '{'{OP_INSERT, 3'd1, 16'd2,     2'd1, 16'd0,     22'd0},       1'b0, '0},
    '{'{OP_INSERT, 3'd1, 16'd3,     2'd0, 16'd1,     22'd0},       1'b0, '0},
    '{'{OP_INSERT, 3'd2, 16'hFFFF,  2'd1, 16'd3,     22'd0},       1'b0, '0},
    '{'{OP_INSERT, 3'd3, 16'd7,     2'd0, 16'd100,   22'd0},       1'b0, '0},
    '{'{OP_INSERT, 3'd4, 16'd9,     2'd2, 16'd2,     22'd0},       1'b0, '0},
    '{'{OP_COMMIT, 3'd0, 16'd0,     2'd0, 16'd0,     22'd0},       1'b1,
      '{ST_OK, 16'd0, 2'd0, 1'b1}},
    '{'{OP_DRAW,   3'd1, 16'd0,     2'd0, 16'd0,     22'd0},       1'b1,
      '{ST_OK, 16'hFFFF, 2'd2, 1'b1}},
    '{'{OP_DRAW,   3'd1, 16'd0,     2'd0, 16'd0,     22'd65535},   1'b0, '0},
    '{'{OP_DRAW,   3'd1, 16'd0,     2'd0, 16'd0,     22'd65536},   1'b0, '0},
    '{'{OP_DRAW,   3'd1, 16'd0,     2'd0, 16'd0,     22'h3FFFFF},  1'b0, '0},
    '{'{OP_DRAW,   3'd0, 16'd0,     2'd0, 16'd0,     22'd1},       1'b1,
      '{ST_BAD_TYPE, 16'd0, 2'd0, 1'b1}},
    '{'{OP_DRAW,   3'd5, 16'd0,     2'd0, 16'd0,     22'd1},       1'b1,
      '{ST_BAD_TYPE, 16'd0, 2'd0, 1'b1}},
    '{'{OP_INSERT, 3'd2, 16'd11,    2'd0, 16'd5,     22'd0},       1'b0, '0},
    '{'{OP_DRAW,   3'd2, 16'd0,     2'd0, 16'd0,     22'd1},       1'b1,
      '{ST_NOT_LOADED, 16'd0, 2'd0, 1'b0}},
    '{'{OP_CLEAR,  3'd0, 16'd0,     2'd0, 16'd0,     22'd0},       1'b1,
      '{ST_OK, 16'd0, 2'd0, 1'b0}}
  };

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [OPC_W-1:0]    in_opcode;
  logic [TYPE_W-1:0]   in_pool_type;
  logic [ID_W-1:0]     in_entry_id;
  logic [RARITY_W-1:0] in_entry_rarity;
  logic [WEIGHT_W-1:0] in_entry_weight;
  logic [ROLL_W-1:0]   in_roll;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] out_status;
  logic [ID_W-1:0]     out_drawn_id;
  logic [RARITY_W-1:0] out_drawn_rarity;
  logic                out_table_loaded;

  // predictor state
  logic [ID_W-1:0]     pool_ids [NT][PD];
  logic [RARITY_W-1:0] pool_rars [NT][PD];
  logic [WEIGHT_W-1:0] pool_wts [NT][PD];
  int                  pool_fill [NT];
  logic [ROLL_W-1:0]   pool_total [NT];
  logic                table_ready;

  draw_res_t outcome_q [$];
  int        err_count;
  int        accepted_items;
  int        burst_left;
  int        cycle_count;
  int        rx_cycles;
  int        rx_mode;
  int        rx_span;
  bit        holdoff_done;

  weighted_pool_draw DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_pool_type     (in_pool_type),
    .in_entry_id      (in_entry_id),
    .in_entry_rarity  (in_entry_rarity),
    .in_entry_weight  (in_entry_weight),
    .in_roll          (in_roll),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_drawn_id     (out_drawn_id),
    .out_drawn_rarity (out_drawn_rarity),
    .out_table_loaded (out_table_loaded)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_pools();
    int i;
    for (i = 0; i < NT; i++) begin
      pool_fill[i] = 0;
      pool_total[i] = '0;
    end
    table_ready = 1'b0;
  endfunction

  function automatic draw_res_t predict_pool_op(input pool_req_t r);
    draw_res_t res;
    int p;
    int n;
    int i;
    bit dup;
    bit hit;
    logic [ROLL_W-1:0] left;
    res = '0;
    p = int'(r.ptype) - 1;
    case (r.op)
      OP_CLEAR: clear_pools();
      OP_INSERT: begin
        table_ready = 1'b0;
        if (p < 0 || p >= NT) begin
          res.status = ST_BAD_TYPE;
        end else if (r.rarity == RARITY_BAD) begin
          res.status = ST_BAD_RARITY;
        end else if (r.id == '0) begin
          res.status = ST_BAD_ID;
        end else begin
          n = pool_fill[p];
          dup = 1'b0;
          for (i = 0; i < n; i++)
            if (pool_ids[p][i] == r.id) dup = 1'b1;
          if (dup) begin
            res.status = ST_DUPLICATE;
          end else if (r.weight != '0) begin
            if (n >= PD) begin
              res.status = ST_FULL;
            end else begin
              pool_ids[p][n] = r.id;
              pool_rars[p][n] = r.rarity;
              pool_wts[p][n] = r.weight;
              pool_fill[p] = n + 1;
              pool_total[p] = pool_total[p] + ROLL_W'(r.weight);
            end
          end
        end
        if (res.status != ST_OK) clear_pools();
      end
      OP_COMMIT: begin
        for (i = 0; i < NT; i++)
          if (pool_total[i] == '0) res.status = ST_EMPTY;
        if (res.status == ST_EMPTY) clear_pools();
        else table_ready = 1'b1;
      end
      default: begin
        if (!table_ready) begin
          res.status = ST_NOT_LOADED;
        end else if (p < 0 || p >= NT) begin
          res.status = ST_BAD_TYPE;
        end else if (pool_fill[p] == 0 || pool_total[p] == '0) begin
          res.status = ST_EMPTY;
        end else begin
          n = pool_fill[p];
          left = r.roll;
          hit = 1'b0;
          for (i = 0; i < n; i++) begin
            if (!hit) begin
              if (left <= ROLL_W'(pool_wts[p][i])) begin
                res.id = pool_ids[p][i];
                res.rarity = pool_rars[p][i];
                hit = 1'b1;
              end else begin
                left = left - ROLL_W'(pool_wts[p][i]);
              end
            end
          end
          if (!hit) begin
            res.id = pool_ids[p][n-1];
            res.rarity = pool_rars[p][n-1];
          end
        end
      end
    endcase
    res.loaded = table_ready;
    return res;
  endfunction

  function automatic pool_req_t mk_req(input logic [OPC_W-1:0] op,
                                       input logic [TYPE_W-1:0] ptype,
                                       input logic [ID_W-1:0] id,
                                       input logic [RARITY_W-1:0] rarity,
                                       input logic [WEIGHT_W-1:0] weight,
                                       input logic [ROLL_W-1:0] roll);
    pool_req_t r;
    r.op = op;
    r.ptype = ptype;
    r.id = id;
    r.rarity = rarity;
    r.weight = weight;
    r.roll = roll;
    return r;
  endfunction

  task automatic send_item(input pool_req_t r, input bit typed = 1'b0,
                           input draw_res_t want = '0);
    int gap;
    draw_res_t got;
    draw_res_t expected;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    in_opcode <= r.op;
    in_pool_type <= r.ptype;
    in_entry_id <= r.id;
    in_entry_rarity <= r.rarity;
    in_entry_weight <= r.weight;
    in_roll <= r.roll;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    accepted_items++;
    got = predict_pool_op(r);
    expected = typed ? want : got;
    outcome_q = {outcome_q, expected};
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
      err_count++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    draw_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (outcome_q.size() == 0) begin
        $display("%0t unexpected result item status %0d id %0d", $time, out_status,
                 out_drawn_id);
        err_count++;
      end else begin
        want = outcome_q.pop_front();
        check_field("status", want.status, out_status);
        check_field("drawn_id", want.id, out_drawn_id);
        check_field("drawn_rarity", want.rarity, out_drawn_rarity);
        check_field("table_loaded", want.loaded, out_table_loaded);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("weighted_pool_draw_tb failed");
      $finish;
    end
  end

  // receiver: stall pattern plus one long hold-off
  initial begin
    out_ready = 1'b0;
    rx_cycles = 0;
    holdoff_done = 1'b0;
    forever begin
      rx_mode = $urandom_range(0, 3);
      rx_span = $urandom_range(16, 200);
      repeat (rx_span) begin
        @(posedge clk);
        rx_cycles++;
        if (!holdoff_done && rx_cycles >= 3000) begin
          out_ready <= 1'b0;
          repeat (600) @(posedge clk);
          rx_cycles += 600;
          holdoff_done = 1'b1;
        end else begin
          case (rx_mode)
            0, 1: out_ready <= 1'b1;
            2: out_ready <= 1'($urandom);
            default: out_ready <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  initial begin
    int row;
    int t;
    int k;
    int cnt;
    int big;
    int nd;
    int dtype;
    logic [WEIGHT_W-1:0] wt;
    logic [ROLL_W-1:0] sum;
    logic [ROLL_W-1:0] roll_v;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_CLEAR;
    in_pool_type = '0;
    in_entry_id = '0;
    in_entry_rarity = '0;
    in_entry_weight = '0;
    in_roll = '0;
    err_count = 0;
    accepted_items = 0;
    burst_left = 0;
    cycle_count = 0;
    clear_pools();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (row = 0; row < N_DIRECTED; row++)
      send_item(DIRECTED[row].req, DIRECTED[row].typed, DIRECTED[row].want);

    while (accepted_items < N_DIRECTED + RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0)
        send_item(mk_req(OP_CLEAR, '0, '0, '0, '0, '0));
      big = ($urandom_range(0, 5) == 0) ? $urandom_range(1, NT) : 0;
      for (t = 1; t <= NT; t++) begin
        cnt = (t == big) ? PD : $urandom_range(1, 6);
        for (k = 0; k < cnt; k++) begin
          case ($urandom_range(0, 9))
            0: wt = (t == big) ? 16'd1 : 16'd0;
            1: wt = 16'hFFFF;
            2: wt = 16'($urandom_range(1, 65535));
            default: wt = 16'($urandom_range(1, 300));
          endcase
          send_item(mk_req(OP_INSERT, TYPE_W'(t), 16'($urandom_range(1, 65535)),
                           2'($urandom_range(0, 2)), wt, '0));
        end
      end
      // broken sequences
      if ($urandom_range(0, 3) == 0)
        send_item(mk_req(2'($urandom), 3'($urandom), 16'($urandom), 2'($urandom),
                         16'($urandom), 22'($urandom)));
      if ($urandom_range(0, 9) == 0 && pool_fill[0] > 0)
        send_item(mk_req(OP_INSERT, 3'd1, pool_ids[0][$urandom_range(0, pool_fill[0]-1)],
                         2'($urandom_range(0, 2)), 16'($urandom_range(1, 65535)), '0));
      send_item(mk_req(OP_COMMIT, '0, '0, '0, '0, '0));
      if ($urandom_range(0, 5) == 0)
        send_item(mk_req(OP_COMMIT, '0, '0, '0, '0, '0));
      nd = $urandom_range(4, 24);
      for (k = 0; k < nd; k++) begin
        if ($urandom_range(0, 9) == 0) dtype = $urandom_range(5, 8) % 8;
        else dtype = $urandom_range(1, NT);
        sum = (dtype >= 1 && dtype <= NT) ? pool_total[dtype-1] : '0;
        case ($urandom_range(0, 9))
          0: roll_v = '0;
          1: roll_v = sum + 22'($urandom_range(1, 1000));
          2: roll_v = '1;
          3: roll_v = 22'($urandom);
          default: roll_v = (sum != '0) ? 22'($urandom_range(1, int'(sum)))
                                        : 22'($urandom_range(1, 1000));
        endcase
        send_item(mk_req(OP_DRAW, TYPE_W'(dtype), 16'($urandom), 2'($urandom),
                         16'($urandom), roll_v));
      end
      if (big != 0 && $urandom_range(0, 1) == 0)
        send_item(mk_req(OP_INSERT, TYPE_W'(big), 16'($urandom_range(1, 65535)),
                         2'($urandom_range(0, 2)), 16'd1, '0));
    end

    in_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (err_count == 0)
      $display("weighted_pool_draw_tb passed");
    else
      $display("weighted_pool_draw_tb failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/wpd_pkg.sv
hw/rtl/wpd_slot_mem.sv
hw/rtl/wpd_cmp_unit.sv
hw/rtl/weighted_pool_draw.sv
bench/weighted_pool_draw_tb.sv
